@@ sv/mdq_pkg.sv @@
// Package: sizes, operation and status codes, word types for the shared-pool deque block.
`default_nettype none
package mdq_pkg;
   localparam int NUM_CELLS   = 1024;
   localparam int NUM_QUEUES  = 16;
   localparam int VALUE_WIDTH = 32;
   localparam int CELL_W      = $clog2(NUM_CELLS);
   localparam int CNT_W       = $clog2(NUM_CELLS + 1);
   localparam int QUEUE_W     = 4;

   localparam logic [2:0] KIND_PUSH_FRONT = 3'd0;
   localparam logic [2:0] KIND_PUSH_BACK  = 3'd1;
   localparam logic [2:0] KIND_POP_FRONT  = 3'd2;
   localparam logic [2:0] KIND_POP_BACK   = 3'd3;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic [2:0]         kind;
      logic [QUEUE_W-1:0] queue_sel;
      logic signed [31:0] push_value;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] removed_value;
      logic signed [31:0] front_value;
      logic signed [31:0] back_value;
      logic               now_empty;
      logic [10:0]        cells_free;
   } rsp_type;
endpackage
`default_nettype wire

@@ sv/mdq_ram.sv @@
// Generic RAM: one write port, one registered read port.
`default_nettype none
module mdq_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 10
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule
`default_nettype wire

@@ sv/multi_deque_shared_pool_top.sv @@
// Several deques as circular doubly linked lists in one shared cell pool.
// The result strobe follows the start word through states ST_0, ST_1 and ST_2 and the registered valid flag.
// A new start word is taken only when idle, after the last word's three steps through the link memories.
// busy is high from acceptance until the result strobe; the receiver cannot stall.
// Reset: synchronous; all queues empty, free stack empty, fresh cells from 0.
`default_nettype none
module multi_deque_shared_pool_top (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            start,
   input  wire mdq_pkg::req_type req,
   output logic                 busy,
   output logic                 rsp_valid,
   output mdq_pkg::rsp_type     rsp
);
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_0    = 2'd1;
   localparam logic [1:0] ST_1    = 2'd2;
   localparam logic [1:0] ST_2    = 2'd3;
   localparam int CW = mdq_pkg::CELL_W;
   localparam int NW = mdq_pkg::CNT_W;
   localparam int VW = mdq_pkg::VALUE_WIDTH;

   logic [1:0]            state_ff, state_in;
   mdq_pkg::req_type      req_ff;
   logic [CW-1:0]         head_ff [mdq_pkg::NUM_QUEUES];
   logic [CW-1:0]         tail_ff [mdq_pkg::NUM_QUEUES];
   logic [VW-1:0]         fval_ff [mdq_pkg::NUM_QUEUES];
   logic [VW-1:0]         bval_ff [mdq_pkg::NUM_QUEUES];
   logic [mdq_pkg::NUM_QUEUES-1:0] ne_ff;
   logic [CW-1:0]         top_ff;
   logic [NW-1:0]         count_ff, fresh_ff;
   logic [CW-1:0]         c_ff, n_ff, p_ff, link_ff;
   logic                  valid_ff;
   mdq_pkg::rsp_type      rsp_ff, rsp_in;

   logic [mdq_pkg::QUEUE_W-1:0] q;
   logic [CW-1:0] h, t, c_sel, c_take;
   logic [VW-1:0] fc, bc, val, front_new, back_new;
   logic          is_push, is_pop, ne, full, push_ok, pop_ok, last, ne_new, kfront;
   logic [NW-1:0] count_new, fresh_new;
   logic [CW-1:0] top_new;

   logic          nx_we, pv_we, vl_we;
   logic [CW-1:0] nx_wa, nx_wd, nx_ra, nx_rd, pv_wa, pv_wd, pv_ra, pv_rd, vl_wa, vl_ra;
   logic [VW-1:0] vl_wd, vl_rd;

   assign q       = req_ff.queue_sel;
   assign h       = head_ff[q];
   assign t       = tail_ff[q];
   assign fc      = fval_ff[q];
   assign bc      = bval_ff[q];
   assign ne      = ne_ff[q];
   assign val     = req_ff.push_value[VW-1:0];
   assign is_push = (req_ff.kind == mdq_pkg::KIND_PUSH_FRONT) ||
                    (req_ff.kind == mdq_pkg::KIND_PUSH_BACK);
   assign is_pop  = (req_ff.kind == mdq_pkg::KIND_POP_FRONT) ||
                    (req_ff.kind == mdq_pkg::KIND_POP_BACK);
   assign kfront  = (req_ff.kind == mdq_pkg::KIND_PUSH_FRONT) ||
                    (req_ff.kind == mdq_pkg::KIND_POP_FRONT);
   assign full    = (count_ff == '0) && (fresh_ff == NW'(mdq_pkg::NUM_CELLS));
   assign push_ok = is_push && !full;
   assign pop_ok  = is_pop && ne;
   assign last    = (h == t);
   assign c_sel   = kfront ? h : t;
   assign c_take  = (count_ff != '0) ? top_ff : fresh_ff[CW-1:0];
   assign busy    = (state_ff != ST_IDLE);

   mdq_ram #(.DEPTH(mdq_pkg::NUM_CELLS), .WIDTH(CW)) u_next (
      .clock(clock), .we(nx_we), .waddr(nx_wa), .wdata(nx_wd), .raddr(nx_ra), .rdata(nx_rd));
   mdq_ram #(.DEPTH(mdq_pkg::NUM_CELLS), .WIDTH(CW)) u_prev (
      .clock(clock), .we(pv_we), .waddr(pv_wa), .wdata(pv_wd), .raddr(pv_ra), .rdata(pv_rd));
   mdq_ram #(.DEPTH(mdq_pkg::NUM_CELLS), .WIDTH(VW)) u_val (
      .clock(clock), .we(vl_we), .waddr(vl_wa), .wdata(vl_wd), .raddr(vl_ra), .rdata(vl_rd));

   always_comb begin
      nx_we = 1'b0; nx_wa = c_ff; nx_wd = c_ff; nx_ra = push_ok ? top_ff : c_sel;
      pv_we = 1'b0; pv_wa = c_ff; pv_wd = c_ff; pv_ra = c_sel;
      vl_we = 1'b0; vl_wa = c_ff; vl_wd = val;  vl_ra = kfront ? nx_rd : pv_rd;
      case (state_ff)
         ST_1: begin
            if (push_ok) begin
               vl_we = 1'b1;
               nx_we = 1'b1; nx_wd = ne ? h : c_ff;
               pv_we = 1'b1; pv_wd = ne ? t : c_ff;
            end else if (pop_ok && !last) begin
               pv_we = 1'b1; pv_wa = nx_rd; pv_wd = pv_rd;
               nx_we = 1'b1; nx_wa = pv_rd; nx_wd = nx_rd;
            end
         end
         ST_2: begin
            if (push_ok && ne) begin
               pv_we = 1'b1; pv_wa = h; pv_wd = c_ff;
               nx_we = 1'b1; nx_wa = t; nx_wd = c_ff;
            end else if (pop_ok) begin
               nx_we = 1'b1; nx_wa = c_ff; nx_wd = top_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      ne_new    = ne;
      front_new = fc;
      back_new  = bc;
      count_new = count_ff;
      fresh_new = fresh_ff;
      top_new   = top_ff;
      if (push_ok) begin
         ne_new = 1'b1;
         if (!ne || kfront) front_new = val;
         if (!ne || !kfront) back_new = val;
         if (count_ff != '0) begin
            top_new   = link_ff;
            count_new = count_ff - NW'(1);
         end else begin
            fresh_new = fresh_ff + NW'(1);
         end
      end else if (pop_ok) begin
         if (last) ne_new = 1'b0;
         else if (kfront) front_new = vl_rd;
         else back_new = vl_rd;
         top_new   = c_ff;
         count_new = count_ff + NW'(1);
      end
      rsp_in.status        = (is_push && full) ? mdq_pkg::STATUS_FULL :
                             (!is_push && !ne) ? mdq_pkg::STATUS_EMPTY : mdq_pkg::STATUS_OK;
      rsp_in.removed_value = pop_ok ? 32'(kfront ? fc : bc) : '0;
      rsp_in.front_value   = ne_new ? 32'(front_new) : '0;
      rsp_in.back_value    = ne_new ? 32'(back_new) : '0;
      rsp_in.now_empty     = !ne_new;
      rsp_in.cells_free    = 11'(count_new + (NW'(mdq_pkg::NUM_CELLS) - fresh_new));
   end

   always_comb begin
      case (state_ff)
         ST_IDLE: state_in = start ? ST_0 : ST_IDLE;
         ST_0:    state_in = ST_1;
         ST_1:    state_in = ST_2;
         ST_2:    state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ne_ff    <= '0;
         top_ff   <= '0;
         count_ff <= '0;
         fresh_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= (state_ff == ST_2);
         if (state_ff == ST_2) begin
            ne_ff[q] <= ne_new;
            top_ff   <= top_new;
            count_ff <= count_new;
            fresh_ff <= fresh_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!busy && start) req_ff <= req;
      if (state_ff == ST_0) c_ff <= push_ok ? c_take : c_sel;
      if (state_ff == ST_1) begin
         link_ff <= nx_rd;
         n_ff    <= nx_rd;
         p_ff    <= pv_rd;
      end
      if (state_ff == ST_2) begin
         rsp_ff  <= rsp_in;
         fval_ff[q] <= front_new;
         bval_ff[q] <= back_new;
         if (push_ok) begin
            if (!ne) begin
               head_ff[q] <= c_ff;
               tail_ff[q] <= c_ff;
            end else if (kfront) begin
               head_ff[q] <= c_ff;
            end else begin
               tail_ff[q] <= c_ff;
            end
         end else if (pop_ok && !last) begin
            if (kfront) head_ff[q] <= n_ff;
            else tail_ff[q] <= p_ff;
         end
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp       = rsp_ff;

   a_rsp_after_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff) == ST_2) else $error("result without final step");
   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("start word not taken");
   a_stack_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= fresh_ff) else $error("free stack larger than used cells");
endmodule
`default_nettype wire

@@ test/tb_top.sv @@
// Testbench for the shared-pool deque block: table-driven directed words, then random traffic.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
   localparam logic [2:0] KIND_QUERY = 3'd4;
   localparam int EXP_DEPTH = 16;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   mdq_pkg::req_type req = '0;
   logic busy;
   logic rsp_valid;
   mdq_pkg::rsp_type rsp;

   multi_deque_shared_pool_top DUT (
      .clock(clock), .reset(reset), .start(start), .req(req),
      .busy(busy), .rsp_valid(rsp_valid), .rsp(rsp)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // deque model
   logic [mdq_pkg::CELL_W-1:0] m_head [mdq_pkg::NUM_QUEUES];
   logic [mdq_pkg::CELL_W-1:0] m_tail [mdq_pkg::NUM_QUEUES];
   logic                       m_used [mdq_pkg::NUM_QUEUES];
   logic [mdq_pkg::CELL_W-1:0] m_next [mdq_pkg::NUM_CELLS];
   logic [mdq_pkg::CELL_W-1:0] m_prev [mdq_pkg::NUM_CELLS];
   logic [31:0]                m_val  [mdq_pkg::NUM_CELLS];
   logic [mdq_pkg::CELL_W-1:0] m_ftop;
   int                         m_fcnt, m_fresh;

   mdq_pkg::rsp_type exp_buf [EXP_DEPTH];
   int exp_wr = 0, exp_rd = 0;
   int errors = 0;
   int n_words = 0, n_full = 0, n_empty = 0;

   function automatic mdq_pkg::rsp_type deque_step(mdq_pkg::req_type w);
      mdq_pkg::rsp_type r;
      int q;
      logic [mdq_pkg::CELL_W-1:0] c, h, t, n, p;
      logic got;
      r = '0;
      q = w.queue_sel % mdq_pkg::NUM_QUEUES;
      if (w.kind == mdq_pkg::KIND_PUSH_FRONT || w.kind == mdq_pkg::KIND_PUSH_BACK) begin
         got = 1'b1;
         if (m_fcnt > 0) begin
            c = m_ftop; m_ftop = m_next[c]; m_fcnt--;
         end else if (m_fresh < mdq_pkg::NUM_CELLS) begin
            c = m_fresh[mdq_pkg::CELL_W-1:0]; m_fresh++;
         end else got = 1'b0;
         if (!got) r.status = mdq_pkg::STATUS_FULL;
         else begin
            m_val[c] = w.push_value;
            if (!m_used[q]) begin
               m_next[c] = c; m_prev[c] = c;
               m_head[q] = c; m_tail[q] = c; m_used[q] = 1'b1;
            end else begin
               h = m_head[q]; t = m_tail[q];
               m_next[c] = h; m_prev[c] = t;
               m_prev[h] = c; m_next[t] = c;
               if (w.kind == mdq_pkg::KIND_PUSH_FRONT) m_head[q] = c;
               else m_tail[q] = c;
            end
         end
      end else if (w.kind == mdq_pkg::KIND_POP_FRONT || w.kind == mdq_pkg::KIND_POP_BACK) begin
         if (!m_used[q]) r.status = mdq_pkg::STATUS_EMPTY;
         else begin
            h = m_head[q]; t = m_tail[q];
            c = (w.kind == mdq_pkg::KIND_POP_FRONT) ? h : t;
            r.removed_value = m_val[c];
            if (h == t) m_used[q] = 1'b0;
            else begin
               n = m_next[c]; p = m_prev[c];
               m_prev[n] = p; m_next[p] = n;
               if (w.kind == mdq_pkg::KIND_POP_FRONT) m_head[q] = n;
               else m_tail[q] = p;
            end
            m_next[c] = m_ftop; m_ftop = c; m_fcnt++;
         end
      end else if (!m_used[q]) r.status = mdq_pkg::STATUS_EMPTY;
      if (m_used[q]) begin
         r.front_value = m_val[m_head[q]];
         r.back_value = m_val[m_tail[q]];
      end else r.now_empty = 1'b1;
      r.cells_free = 11'(m_fcnt + mdq_pkg::NUM_CELLS - m_fresh);
      return r;
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (exp_wr == exp_rd) begin
            $display("%0t unexpected word: expected none, actual %p", $time, rsp);
            errors++;
         end else begin
            if (rsp !== exp_buf[exp_rd % EXP_DEPTH]) begin
               $display("%0t mismatch: expected %p, actual %p", $time,
                        exp_buf[exp_rd % EXP_DEPTH], rsp);
               errors++;
            end
            exp_rd++;
         end
      end
   end

   task automatic send_word(mdq_pkg::req_type w, logic check_fixed, mdq_pkg::rsp_type fixed,
                            logic quiet);
      mdq_pkg::rsp_type e;
      if (!quiet && $urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 16)) @(posedge clock);
      start <= 1'b1;
      req <= w;
      @(posedge clock);
      while (busy) @(posedge clock);
      e = deque_step(w);
      if (check_fixed && e !== fixed) begin
         $display("%0t table mismatch: expected %p, actual %p", $time, fixed, e);
         errors++;
      end
      exp_buf[exp_wr % EXP_DEPTH] = e;
      exp_wr++;
      n_words++;
      if (e.status == mdq_pkg::STATUS_FULL) n_full++;
      if (e.status == mdq_pkg::STATUS_EMPTY) n_empty++;
      start <= 1'b0;
      @(posedge clock);
   endtask

   typedef struct {
      mdq_pkg::req_type w;
      logic             fixed;
      mdq_pkg::rsp_type r;
   } row_type;

   function automatic mdq_pkg::req_type mk(logic [2:0] k, logic [3:0] q, logic [31:0] v);
      mdq_pkg::req_type w;
      w.kind = k; w.queue_sel = q; w.push_value = v;
      return w;
   endfunction

   function automatic mdq_pkg::rsp_type rs(logic [1:0] s, logic [31:0] rm, logic [31:0] f,
                                           logic [31:0] b, logic e, logic [10:0] c);
      mdq_pkg::rsp_type r;
      r.status = s; r.removed_value = rm; r.front_value = f;
      r.back_value = b; r.now_empty = e; r.cells_free = c;
      return r;
   endfunction

   initial begin
      row_type rows [16];
      mdq_pkg::req_type w;
      int k, q, depth;
      for (int i = 0; i < mdq_pkg::NUM_QUEUES; i++) m_used[i] = 1'b0;
      m_ftop = '0; m_fcnt = 0; m_fresh = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      rows[0]  = '{mk(KIND_QUERY, 0, 0), 1, rs(mdq_pkg::STATUS_EMPTY, 0, 0, 0, 1, 1024)};
      rows[1]  = '{mk(mdq_pkg::KIND_POP_FRONT, 15, 0), 1,
                   rs(mdq_pkg::STATUS_EMPTY, 0, 0, 0, 1, 1024)};
      rows[2]  = '{mk(mdq_pkg::KIND_POP_BACK, 3, 0), 1,
                   rs(mdq_pkg::STATUS_EMPTY, 0, 0, 0, 1, 1024)};
      rows[3]  = '{mk(mdq_pkg::KIND_PUSH_BACK, 15, 32'h7fffffff), 1,
                   rs(mdq_pkg::STATUS_OK, 0, 32'h7fffffff, 32'h7fffffff, 0, 1023)};
      rows[4]  = '{mk(mdq_pkg::KIND_PUSH_FRONT, 15, 32'h80000000), 1,
                   rs(mdq_pkg::STATUS_OK, 0, 32'h80000000, 32'h7fffffff, 0, 1022)};
      rows[5]  = '{mk(mdq_pkg::KIND_PUSH_BACK, 15, 32'hffffffff), 0, '0};
      rows[6]  = '{mk(3'd7, 15, 0), 0, '0};
      rows[7]  = '{mk(3'd5, 4, 32'h5a5a5a5a), 0, '0};
      rows[8]  = '{mk(mdq_pkg::KIND_POP_FRONT, 15, 0), 0, '0};
      rows[9]  = '{mk(mdq_pkg::KIND_POP_BACK, 15, 0), 0, '0};
      rows[10] = '{mk(mdq_pkg::KIND_PUSH_FRONT, 0, 32'h12345678), 0, '0};
      rows[11] = '{mk(mdq_pkg::KIND_POP_BACK, 15, 0), 0, '0};
      rows[12] = '{mk(mdq_pkg::KIND_POP_FRONT, 15, 0), 1,
                   rs(mdq_pkg::STATUS_EMPTY, 0, 0, 0, 1, 1023)};
      rows[13] = '{mk(mdq_pkg::KIND_PUSH_BACK, 6, 32'h0), 0, '0};
      rows[14] = '{mk(mdq_pkg::KIND_POP_FRONT, 0, 0), 0, '0};
      rows[15] = '{mk(mdq_pkg::KIND_POP_FRONT, 6, 0), 1,
                   rs(mdq_pkg::STATUS_OK, 0, 0, 0, 1, 1024)};
      foreach (rows[i]) send_word(rows[i].w, rows[i].fixed, rows[i].r, 1'b0);

      // let every outstanding result come back before random traffic
      while (exp_wr != exp_rd) @(posedge clock);

      for (int i = 0; i < 880; i++) begin
         depth = $urandom_range(0, 99);
         if (depth < 45) k = $urandom_range(0, 1);
         else if (depth < 85) k = $urandom_range(2, 3);
         else k = $urandom_range(4, 7);
         q = (i < 440) ? $urandom_range(0, 3) : $urandom_range(0, 15);
         w = mk(3'(k), 4'(q), $urandom);
         send_word(w, 0, '0, i >= 780);
      end

      while (exp_wr != exp_rd) @(posedge clock);
      repeat (8) @(posedge clock);
      $display("Ran %0d words: directed table plus random pushes, pops and queries;", n_words);
      $display("%0d pool-full and %0d empty-queue results seen.", n_full, n_empty);
      if (errors == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

   initial begin
      #20ms;
      $display("TB_ERROR");
      $finish;
   end
endmodule
`default_nettype wire

@@ files.f @@
sv/mdq_pkg.sv
sv/mdq_ram.sv
sv/multi_deque_shared_pool_top.sv
test/tb_top.sv
